/* rtl/core/udsrsp_pkg.sv */
// ----------------------------------------------------------------------------
// UDS responder package
// Shared types, register indexes and protocol constants for the UDS over
// ISO-TP ECU responder.
// ----------------------------------------------------------------------------
`default_nettype none

package udsrsp_pkg;

	localparam int unsigned IdW    = 29;
	localparam int unsigned LenW   = 4;
	localparam int unsigned NBytes = 8;
	localparam int unsigned RemW   = 13;

	typedef logic [NBytes-1:0][7:0] payload_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_REQUEST_ID    = 3'd0,
		REG_RESPONSE_ID   = 3'd1,
		REG_STREAM_GAP    = 3'd2,
		REG_FLOW_REPLY_EN = 3'd3,
		REG_AUTO_REPLY_EN = 3'd4,
		REG_EXT_DEFAULT   = 3'd5,
		REG_SEPARATOR_EN  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [IdW-1:0] request_id;
		logic [IdW-1:0] response_id;
		logic [7:0]     stream_gap;
		logic           flow_reply_en;
		logic           auto_reply_en;
		logic           ext_default;
		logic           separator_en;
	} cfg_t;

	typedef struct packed {
		logic [IdW-1:0]  id;
		logic [LenW-1:0] len;
		payload_t        data;
	} frame_t;

	typedef struct packed {
		logic     kind;
		logic     cut;
		logic     ext;
		payload_t data;
	} result_t;

	// result kinds
	localparam logic KIND_REPLY   = 1'b0;
	localparam logic KIND_SEQ_ERR = 1'b1;

	// UDS service identifiers
	localparam logic [7:0] SID_SESSION  = 8'h10;
	localparam logic [7:0] SID_SECURITY = 8'h27;
	localparam logic [7:0] SID_ROUTINE  = 8'h31;
	localparam logic [7:0] SID_DOWNLOAD = 8'h34;
	localparam logic [7:0] SID_TRANSFER = 8'h36;
	localparam logic [7:0] SID_XFER_END = 8'h37;
	localparam logic [7:0] SID_WRITE    = 8'h3B;

	// positive response codes
	localparam logic [7:0] RSP_SESSION  = 8'h50;
	localparam logic [7:0] RSP_SECURITY = 8'h67;
	localparam logic [7:0] RSP_ROUTINE  = 8'h71;
	localparam logic [7:0] RSP_DOWNLOAD = 8'h74;
	localparam logic [7:0] RSP_TRANSFER = 8'h76;
	localparam logic [7:0] RSP_XFER_END = 8'h77;
	localparam logic [7:0] RSP_WRITE    = 8'h7B;
	localparam logic [7:0] RSP_OFFSET   = 8'h40;

	// ISO-TP framing
	localparam logic [7:0] PCI_FLOW     = 8'h30;
	localparam logic [7:0] SEQ_INIT     = 8'h20;
	localparam logic [7:0] SEQ_WRAP_HI  = 8'h2F;
	localparam logic [7:0] SEQ_WRAP_LO  = 8'h1F;
	localparam logic [7:0] PAD_BYTE     = 8'hFF;
	localparam logic [RemW-1:0] FF_PAYLOAD = 13'd6;
	localparam logic [RemW-1:0] CF_PAYLOAD = 13'd7;

	// canned reply bytes
	localparam logic [7:0] P2_HI        = 8'h00;
	localparam logic [7:0] P2_LO        = 8'h32;
	localparam logic [7:0] P2X_HI       = 8'h01;
	localparam logic [7:0] P2X_LO       = 8'hEA;
	localparam logic [7:0] SEED_0       = 8'h1A;
	localparam logic [7:0] SEED_1       = 8'h2B;
	localparam logic [7:0] SEED_2       = 8'h3C;
	localparam logic [7:0] SEED_3       = 8'h4D;
	localparam logic [7:0] RTN_ERASE_HI = 8'hFA;
	localparam logic [7:0] DL_LEN_FMT   = 8'h20;
	localparam logic [7:0] DL_BLK_HI    = 8'h0F;
	localparam logic [7:0] DL_BLK_LO    = 8'hFF;

endpackage

`default_nettype wire

/* rtl/core/udsrsp_cfg.sv */
// ----------------------------------------------------------------------------
// UDS responder configuration registers
// Write-only register file behind the plain configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module udsrsp_cfg
	import udsrsp_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [IdW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_REQUEST_ID:    cfg_q.request_id    <= cfg_data;
				REG_RESPONSE_ID:   cfg_q.response_id   <= cfg_data;
				REG_STREAM_GAP:    cfg_q.stream_gap    <= cfg_data[7:0];
				REG_FLOW_REPLY_EN: cfg_q.flow_reply_en <= cfg_data[0];
				REG_AUTO_REPLY_EN: cfg_q.auto_reply_en <= cfg_data[0];
				REG_EXT_DEFAULT:   cfg_q.ext_default   <= cfg_data[0];
				REG_SEPARATOR_EN:  cfg_q.separator_en  <= cfg_data[0];
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/udsrsp_core.sv */
// ----------------------------------------------------------------------------
// UDS responder core
// Session state (sequence counter, remaining length, stored reply) and the
// single-pass reply builder for one received frame.
// ----------------------------------------------------------------------------
`default_nettype none

module udsrsp_core
	import udsrsp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   fire,
	input  wire frame_t frame,
	output logic        res_valid,
	output result_t     res
);

	logic [7:0]             seq_q, seq_d;
	logic signed [RemW-1:0] rem_q, rem_d, rem_dec;
	payload_t               pend_q, pend_d;

	payload_t   d, tx;
	logic [7:0] d0, d1, d2;
	logic       hit, send, cut, err, pad_on;

	assign d  = frame.data;
	assign d0 = d[0];
	assign d1 = d[1];
	assign d2 = d[2];

	// flow-control frames and foreign identifiers are not answered
	assign hit = (frame.id == cfg.request_id) && (frame.len != '0) &&
		!(d0[5] && d0[4]);

	always_comb begin
		tx      = '0;
		send    = 1'b0;
		cut     = 1'b0;
		err     = 1'b0;
		seq_d   = seq_q;
		rem_d   = rem_q;
		pend_d  = pend_q;
		rem_dec = rem_q - $signed(CF_PAYLOAD);

		if (hit) begin
			if (d0[7:3] == 5'd0) begin
				// single frame
				send = 1'b1;
				cut  = 1'b1;
				case (d1)
					SID_SESSION: begin
						tx[0] = 8'h06;  tx[1] = RSP_SESSION; tx[2] = d2;
						tx[3] = P2_HI;  tx[4] = P2_LO;
						tx[5] = P2X_HI; tx[6] = P2X_LO;
					end
					SID_SECURITY: begin
						tx[1] = RSP_SECURITY;
						tx[2] = d2;
						if (d2[0]) begin
							tx[0] = 8'h06;
							tx[3] = SEED_0; tx[4] = SEED_1;
							tx[5] = SEED_2; tx[6] = SEED_3;
						end else begin
							tx[0] = 8'h02;
						end
					end
					SID_ROUTINE: begin
						tx[1] = RSP_ROUTINE;
						if (d2 == RTN_ERASE_HI && d[3] == PAD_BYTE) begin
							tx[0] = d0;
							tx[2] = d2;
						end else if ((d[3] == 8'h02 && d[4] == 8'h02) ||
								(d[3] == 8'hFF && d[4] == 8'h00)) begin
							tx[0] = d0 - 8'd1;
							tx[2] = d2;
							tx[3] = d[3];
							tx[4] = d[4];
						end else begin
							// echo the routine record up to its length, then a zero
							tx[0] = d0 + 8'd1;
							for (int k = 2; k < NBytes; k++) begin
								tx[k] = (8'(k) <= d0) ? d[k] : 8'h00;
							end
						end
					end
					SID_XFER_END: begin
						tx[0] = 8'h01;
						tx[1] = RSP_XFER_END;
					end
					SID_WRITE: begin
						tx[0] = 8'h02;
						tx[1] = RSP_WRITE;
						tx[2] = d2;
					end
					default: begin
						for (int k = 0; k < NBytes; k++) begin
							tx[k] = (LenW'(k) < frame.len) ? d[k] : 8'h00;
						end
						tx[1] = tx[1] + RSP_OFFSET;
					end
				endcase
			end else if (d0[4]) begin
				// first frame: answer with flow control, hold the final reply
				tx[0] = PCI_FLOW;
				tx[2] = cfg.stream_gap;
				send  = cfg.flow_reply_en;
				seq_d = SEQ_INIT;
				rem_d = $signed({1'b0, d0[3:0], d1} - FF_PAYLOAD);
				case (d2)
					SID_ROUTINE: begin
						pend_d[0] = 8'h05; pend_d[1] = RSP_ROUTINE;
						pend_d[2] = d[3];  pend_d[3] = d[4];
						pend_d[4] = d[5];  pend_d[5] = 8'h00;
					end
					SID_DOWNLOAD: begin
						pend_d[0] = 8'h04;       pend_d[1] = RSP_DOWNLOAD;
						pend_d[2] = DL_LEN_FMT;  pend_d[3] = DL_BLK_HI;
						pend_d[4] = DL_BLK_LO;
					end
					SID_WRITE: begin
						pend_d[0] = 8'h02; pend_d[1] = RSP_WRITE; pend_d[2] = d[3];
					end
					SID_SECURITY: begin
						pend_d[0] = 8'h02; pend_d[1] = RSP_SECURITY; pend_d[2] = d[3];
					end
					SID_TRANSFER: begin
						pend_d[0] = 8'h02; pend_d[1] = RSP_TRANSFER; pend_d[2] = d[3];
					end
					default: begin
						pend_d[0] = 8'h02;
						pend_d[1] = d2 + RSP_OFFSET;
						pend_d[2] = d[3];
					end
				endcase
			end else if (d0[5]) begin
				// consecutive frame
				seq_d = d0;
				if ({1'b0, seq_q} + 9'd1 == {1'b0, d0}) begin
					if (d0 == SEQ_WRAP_HI) begin
						seq_d = SEQ_WRAP_LO;
					end
					if (pend_q[0] != 8'h00) begin
						rem_d = rem_dec;
						if (rem_dec[RemW-1] || rem_dec == '0) begin
							tx     = pend_q;
							pend_d = '0;
							send   = 1'b1;
							cut    = 1'b1;
						end
					end
				end else begin
					err = 1'b1;
				end
			end
		end

		// pad after the PCI length
		pad_on = (tx[0] != 8'h00) && (tx[0] < 8'h07);
		for (int k = 2; k < NBytes; k++) begin
			if (pad_on && (8'(k - 1) >= tx[0])) begin
				tx[k] = PAD_BYTE;
			end
		end

		res_valid = hit && (err || (send && cfg.auto_reply_en));
		if (err) begin
			res.kind = KIND_SEQ_ERR;
			res.cut  = 1'b0;
			res.ext  = 1'b0;
			res.data = d;
		end else begin
			res.kind = KIND_REPLY;
			res.cut  = cut && cfg.separator_en;
			res.ext  = (cfg.response_id[IdW-1:16] != '0) || cfg.ext_default;
			res.data = tx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= SEQ_INIT;
			rem_q  <= '0;
			pend_q <= '0;
		end else if (fire) begin
			seq_q  <= seq_d;
			rem_q  <= rem_d;
			pend_q <= pend_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/uds_isotp_ecu_responder.sv */
// ----------------------------------------------------------------------------
// UDS over ISO-TP ECU responder
// Answers diagnostic requests arriving as CAN frames with canned replies.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one received CAN frame per
//   request: identifier, length code and the eight payload bytes.
//   Output channel (out_valid / out_stall) carries at most one result per
//   request: a reply frame to transmit or a consecutive-frame sequence error.
//   Requests that draw no reply (foreign identifier, empty, flow control,
//   replies disabled) leave no result; disabled ones update the session state.
//   A request is taken into the input register, then its result into the
//   result register. Throughput: one request per cycle unless the receiver
//   stalls, set by the single-pass reply logic between the two registers.
//   While the receiver stalls, the held result waits in the result register
//   and the input register holds its request; in_stall rises once both are
//   full. Configuration is written through cfg_wr_en / cfg_index / cfg_data
//   while the block is idle.
//   Reset clears the valid flags and the configuration, the sequence counter
//   returns to 0x20 and any stored reply is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module uds_isotp_ecu_responder
	import udsrsp_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	// configuration
	input  wire logic            cfg_wr_en,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [IdW-1:0]  cfg_data,
	// received frame
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [IdW-1:0]  rx_id,
	input  wire logic [LenW-1:0] rx_len,
	input  wire logic [7:0]      rx_byte0,
	input  wire logic [7:0]      rx_byte1,
	input  wire logic [7:0]      rx_byte2,
	input  wire logic [7:0]      rx_byte3,
	input  wire logic [7:0]      rx_byte4,
	input  wire logic [7:0]      rx_byte5,
	input  wire logic [7:0]      rx_byte6,
	input  wire logic [7:0]      rx_byte7,
	// result
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 resp_kind,
	output logic                 cut_line,
	output logic                 ext_frame,
	output logic [7:0]           tx_byte0,
	output logic [7:0]           tx_byte1,
	output logic [7:0]           tx_byte2,
	output logic [7:0]           tx_byte3,
	output logic [7:0]           tx_byte4,
	output logic [7:0]           tx_byte5,
	output logic [7:0]           tx_byte6,
	output logic [7:0]           tx_byte7
);

	cfg_t    cfg;
	frame_t  frame_s1;
	logic    valid_s1;
	logic    out_free, fire, accept, res_valid;
	result_t res, res_q;
	logic    out_valid_q;

	udsrsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1.id   <= rx_id;
			frame_s1.len  <= rx_len;
			frame_s1.data <= {rx_byte7, rx_byte6, rx_byte5, rx_byte4,
				rx_byte3, rx_byte2, rx_byte1, rx_byte0};
		end
	end

	udsrsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.frame     (frame_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign resp_kind = res_q.kind;
	assign cut_line  = res_q.cut;
	assign ext_frame = res_q.ext;
	assign tx_byte0  = res_q.data[0];
	assign tx_byte1  = res_q.data[1];
	assign tx_byte2  = res_q.data[2];
	assign tx_byte3  = res_q.data[3];
	assign tx_byte4  = res_q.data[4];
	assign tx_byte5  = res_q.data[5];
	assign tx_byte6  = res_q.data[6];
	assign tx_byte7  = res_q.data[7];

endmodule

`default_nettype wire
